// File: hw/rtl/vrra_pkg.sv
// ----------------------------------------------------------------------------
// vrra_pkg
// Shared types, constants and codes of the variable record ring allocator.
// ----------------------------------------------------------------------------
package vrra_pkg;

  // ring geometry (both powers of two)
  localparam int RING_BLOCKS = 256;
  localparam int BLOCK_BYTES = 16;
  localparam int IDX_W       = $clog2(RING_BLOCKS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  // field widths
  localparam int KIND_W   = 2;
  localparam int TYPE_W   = 16;
  localparam int BYTES_W  = 16;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 8;
  localparam int REC_IDX_W = 8;
  localparam int REC_BLK_W = 9;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_W  = APB_ADDR_W - 2;
  localparam logic [REG_SEL_W-1:0] REG_SPILL_WHEN_FULL = '0;

  typedef enum logic [KIND_W-1:0] {
    KIND_RESERVE = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_PEEK    = 2'd2,
    KIND_POP     = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_STATE = 2'd3
  } status_t;

  // one header entry
  typedef struct packed {
    logic [TYPE_W-1:0] rtype;
    logic [CNT_W-1:0]  blocks;
    logic              ext;
  } hdr_t;

  // configuration handed to the core
  typedef struct packed {
    logic spill_when_full;
  } cfg_t;

endpackage

// File: hw/rtl/vrra_in_if.sv
// ----------------------------------------------------------------------------
// vrra_in_if
// Request channel: valid/ready handshake carrying one operation.
// ----------------------------------------------------------------------------
interface vrra_in_if;
  logic                         valid;
  logic                         ready;
  logic [vrra_pkg::KIND_W-1:0]  kind;
  logic [vrra_pkg::TYPE_W-1:0]  record_type;
  logic [vrra_pkg::BYTES_W-1:0] payload_bytes;

  modport source (output valid, output kind, output record_type, output payload_bytes,
                  input ready);
  modport sink (input valid, input kind, input record_type, input payload_bytes,
                output ready);
endinterface

// File: hw/rtl/vrra_out_if.sv
// ----------------------------------------------------------------------------
// vrra_out_if
// Result channel: valid/ready handshake carrying one result.
// ----------------------------------------------------------------------------
interface vrra_out_if;
  logic                           valid;
  logic                           ready;
  logic [vrra_pkg::STATUS_W-1:0]  status;
  logic [vrra_pkg::REC_IDX_W-1:0] record_index;
  logic [vrra_pkg::REC_BLK_W-1:0] record_blocks;
  logic [vrra_pkg::FILL_W-1:0]    pad_blocks;
  logic [vrra_pkg::TYPE_W-1:0]    head_type;
  logic                           external_payload;
  logic                           ring_empty;

  modport source (output valid, output status, output record_index, output record_blocks,
                  output pad_blocks, output head_type, output external_payload,
                  output ring_empty, input ready);
  modport sink (input valid, input status, input record_index, input record_blocks,
                input pad_blocks, input head_type, input external_payload,
                input ring_empty, output ready);
endinterface

// File: hw/rtl/variable_record_ring_allocator_top.sv
// ----------------------------------------------------------------------------
// variable_record_ring_allocator_top
// Ring allocator for variable-length records with an APB control register.
// ----------------------------------------------------------------------------
// Each operation (reserve, commit, peek, pop) passes through the operation
// stage register and then the result register; one operation is accepted per
// clock while the result side keeps up. The rate is set by the head-pointer
// loop: the header RAM is read at the next head position, and a pop's new
// head comes from that header plus one add.
// The header store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module variable_record_ring_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  vrra_in_if.sink                         in_ch,
  vrra_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vrra_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vrra_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vrra_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  vrra_pkg::cfg_t cfg;

  vrra_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vrra_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// File: hw/rtl/vrra_ram.sv
// ----------------------------------------------------------------------------
// vrra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vrra_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/vrra_apb_regs.sv
// ----------------------------------------------------------------------------
// vrra_apb_regs
// APB register file: holds the spill_when_full control bit.
// ----------------------------------------------------------------------------
module vrra_apb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vrra_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vrra_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vrra_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output vrra_pkg::cfg_t                  cfg
);

  logic                               spill_when_full;
  logic [vrra_pkg::REG_SEL_W-1:0]     reg_sel;
  logic                               wr_fire;

  assign pready  = 1'b1;
  assign reg_sel = paddr[vrra_pkg::APB_ADDR_W-1:2];
  assign wr_fire = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      spill_when_full <= 1'b0;
    end else if (wr_fire && (reg_sel == vrra_pkg::REG_SPILL_WHEN_FULL)) begin
      spill_when_full <= pwdata[0];
    end
  end

  // read decode
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      vrra_pkg::REG_SPILL_WHEN_FULL: prdata[0] = spill_when_full;
      default:                       prdata = '0;
    endcase
  end

  assign cfg.spill_when_full = spill_when_full;

endmodule

// File: hw/rtl/vrra_core.sv
// ----------------------------------------------------------------------------
// vrra_core
// Operation stage, pointer state, header store and result register.
// ----------------------------------------------------------------------------
module vrra_core (
  input  logic           clk,
  input  logic           rst,
  input  vrra_pkg::cfg_t cfg,
  vrra_in_if.sink        in_ch,
  vrra_out_if.source     out_ch
);

  localparam int IDX_W  = vrra_pkg::IDX_W;
  localparam int CNT_W  = vrra_pkg::CNT_W;
  localparam int FIT_W  = CNT_W + 1;
  localparam int BEXT_W = vrra_pkg::BYTES_W + 1;
  localparam int HALF_BYTES = vrra_pkg::BLOCK_BYTES * vrra_pkg::RING_BLOCKS / 2;
  localparam int HDR_W  = $bits(vrra_pkg::hdr_t);

  // operation stage
  logic                         stage_valid;
  vrra_pkg::kind_t              stage_kind;
  logic [vrra_pkg::TYPE_W-1:0]  stage_type;
  logic [vrra_pkg::BYTES_W-1:0] stage_bytes;

  // pointer state
  logic [IDX_W-1:0] read_pos, read_pos_next;
  logic [IDX_W-1:0] write_pos, write_pos_next;
  logic [IDX_W-1:0] pending_end, pending_end_next;
  logic             reserve_open, reserve_open_next;

  // live filler header, kept beside the RAM
  logic             filler_valid, filler_valid_next;
  logic [IDX_W-1:0] filler_pos, filler_pos_next;
  logic [CNT_W-1:0] filler_cnt, filler_cnt_next;

  // header RAM and write bypass
  logic             hdr_we;
  logic [IDX_W-1:0] hdr_waddr;
  vrra_pkg::hdr_t   hdr_wdata;
  logic [HDR_W-1:0] hdr_rdata;
  logic             byp_hit;
  vrra_pkg::hdr_t   byp_data;
  vrra_pkg::hdr_t   hdr_cur;

  // result register
  logic                           out_valid;
  vrra_pkg::status_t              res_status;
  logic [vrra_pkg::REC_IDX_W-1:0] res_index;
  logic [vrra_pkg::REC_BLK_W-1:0] res_blocks;
  logic [vrra_pkg::FILL_W-1:0]    res_filler;
  logic [vrra_pkg::TYPE_W-1:0]    res_type;
  logic                           res_ext;
  logic                           res_empty;

  // combinational result
  vrra_pkg::status_t              c_status;
  logic [IDX_W-1:0]               c_index;
  logic [CNT_W-1:0]               c_blocks;
  logic [CNT_W-1:0]               c_filler;
  logic [vrra_pkg::TYPE_W-1:0]    c_type;
  logic                           c_ext;

  // reserve sizing
  logic [BEXT_W-1:0] bytes_ext;
  logic              ext0, ext_f;
  logic [CNT_W-1:0]  nblk_inl, nblk0, nblk_f;
  logic [CNT_W-1:0]  contig, fill0, fill1, fill_f;
  logic [IDX_W-1:0]  free_cnt;
  logic              fits0, fits1, fits_f, retry;
  logic [IDX_W-1:0]  rec_at;

  logic stage_fire;
  logic in_fire;

  // handshakes
  assign stage_fire   = stage_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !stage_valid || stage_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_kind  <= vrra_pkg::kind_t'(in_ch.kind);
      stage_type  <= in_ch.record_type;
      stage_bytes <= in_ch.payload_bytes;
    end
  end

  // head header: filler register, then bypass, then RAM
  always_comb begin
    if (filler_valid && (filler_pos == read_pos)) begin
      hdr_cur.rtype  = '0;
      hdr_cur.blocks = filler_cnt;
      hdr_cur.ext    = 1'b0;
    end else if (byp_hit) begin
      hdr_cur = byp_data;
    end else begin
      hdr_cur = vrra_pkg::hdr_t'(hdr_rdata);
    end
  end

  // reserve sizing and fit check
  always_comb begin
    bytes_ext = {1'b0, stage_bytes};
    ext0      = (bytes_ext + BEXT_W'(vrra_pkg::BLOCK_BYTES)) > BEXT_W'(HALF_BYTES);
    nblk_inl  = CNT_W'(1) + CNT_W'((bytes_ext + BEXT_W'(vrra_pkg::BLOCK_BYTES - 1))
                                   >> vrra_pkg::BLOCK_SHIFT);
    nblk0     = ext0 ? CNT_W'(1) : nblk_inl;
    contig    = CNT_W'(vrra_pkg::RING_BLOCKS) - {1'b0, write_pos};
    free_cnt  = read_pos - write_pos - IDX_W'(1);
    fill0     = (nblk0 > contig) ? contig : '0;
    fits0     = (FIT_W'(nblk0) + FIT_W'(fill0)) <= FIT_W'(free_cnt);
    // spill retry as a single-block external record
    fill1     = (CNT_W'(1) > contig) ? contig : '0;
    fits1     = (FIT_W'(1) + FIT_W'(fill1)) <= FIT_W'(free_cnt);
    retry     = !fits0 && cfg.spill_when_full && !ext0 && (stage_bytes != '0);
    ext_f     = retry ? 1'b1 : ext0;
    nblk_f    = retry ? CNT_W'(1) : nblk0;
    fill_f    = retry ? fill1 : fill0;
    fits_f    = retry ? fits1 : fits0;
    rec_at    = (fill_f != '0) ? '0 : write_pos;
  end

  // operation decode and next state
  always_comb begin
    read_pos_next     = read_pos;
    write_pos_next    = write_pos;
    pending_end_next  = pending_end;
    reserve_open_next = reserve_open;
    filler_valid_next = filler_valid;
    filler_pos_next   = filler_pos;
    filler_cnt_next   = filler_cnt;
    hdr_we            = 1'b0;
    hdr_waddr         = rec_at;
    hdr_wdata.rtype   = stage_type;
    hdr_wdata.blocks  = nblk_f;
    hdr_wdata.ext     = ext_f;
    c_status          = vrra_pkg::ST_OK;
    c_index           = '0;
    c_blocks          = '0;
    c_filler          = '0;
    c_type            = '0;
    c_ext             = 1'b0;
    unique case (stage_kind)
      vrra_pkg::KIND_RESERVE: begin
        if (reserve_open) begin
          c_status = vrra_pkg::ST_BAD_STATE;
        end else if (!fits_f) begin
          c_status = vrra_pkg::ST_FULL;
        end else begin
          hdr_we            = stage_fire;
          pending_end_next  = IDX_W'({1'b0, write_pos} + nblk_f + fill_f);
          reserve_open_next = 1'b1;
          c_index           = rec_at;
          c_blocks          = nblk_f;
          c_filler          = fill_f;
          c_ext             = ext_f;
          if (fill_f != '0) begin
            filler_valid_next = 1'b1;
            filler_pos_next   = write_pos;
            filler_cnt_next   = fill_f;
          end else if (rec_at == filler_pos) begin
            filler_valid_next = 1'b0;
          end
        end
      end
      vrra_pkg::KIND_COMMIT: begin
        if (!reserve_open) begin
          c_status = vrra_pkg::ST_BAD_STATE;
        end else begin
          write_pos_next    = pending_end;
          reserve_open_next = 1'b0;
        end
      end
      vrra_pkg::KIND_PEEK, vrra_pkg::KIND_POP: begin
        if (read_pos == write_pos) begin
          c_status = vrra_pkg::ST_EMPTY;
        end else begin
          c_index  = read_pos;
          c_blocks = hdr_cur.blocks;
          c_type   = hdr_cur.rtype;
          c_ext    = hdr_cur.ext;
          if (stage_kind == vrra_pkg::KIND_POP) begin
            read_pos_next = IDX_W'({1'b0, read_pos} + hdr_cur.blocks);
          end
        end
      end
      default: c_status = vrra_pkg::ST_BAD_STATE;
    endcase
    // hold everything unless the operation retires this cycle
    if (!stage_fire) begin
      read_pos_next     = read_pos;
      write_pos_next    = write_pos;
      pending_end_next  = pending_end;
      reserve_open_next = reserve_open;
      filler_valid_next = filler_valid;
      filler_pos_next   = filler_pos;
      filler_cnt_next   = filler_cnt;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pos     <= '0;
      write_pos    <= '0;
      pending_end  <= '0;
      reserve_open <= 1'b0;
      filler_valid <= 1'b0;
    end else begin
      read_pos     <= read_pos_next;
      write_pos    <= write_pos_next;
      pending_end  <= pending_end_next;
      reserve_open <= reserve_open_next;
      filler_valid <= filler_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    filler_pos <= filler_pos_next;
    filler_cnt <= filler_cnt_next;
  end

  // header store, read at the head position of the next cycle
  vrra_ram #(
    .WIDTH (HDR_W),
    .DEPTH (vrra_pkg::RING_BLOCKS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (hdr_wdata),
    .raddr (read_pos_next),
    .rdata (hdr_rdata)
  );

  // same-cycle write to the address being read
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= hdr_we && (hdr_waddr == read_pos_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= hdr_wdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      res_status <= c_status;
      res_index  <= vrra_pkg::REC_IDX_W'(c_index);
      res_blocks <= vrra_pkg::REC_BLK_W'(c_blocks);
      res_filler <= vrra_pkg::FILL_W'(c_filler);
      res_type   <= c_type;
      res_ext    <= c_ext;
      res_empty  <= (read_pos_next == write_pos_next);
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.status           = res_status;
  assign out_ch.record_index     = res_index;
  assign out_ch.record_blocks    = res_blocks;
  assign out_ch.pad_blocks       = res_filler;
  assign out_ch.head_type        = res_type;
  assign out_ch.external_payload = res_ext;
  assign out_ch.ring_empty       = res_empty;

endmodule

// File: sim/tb_variable_record_ring_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_variable_record_ring_allocator_top
// Self-checking bench for the variable record ring allocator.
// A scoreboard class predicts every result from its own copy of the ring
// pointers and header store. Directed traffic covers empty, full, filler,
// external and bad-state cases. Random phases then run reserve/commit pairs
// against pops and peeks under both spill settings. The phases add random
// idling, one long result-side stall and drain points between phases.
// ----------------------------------------------------------------------------
module tb_variable_record_ring_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vrra_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int PHASE_OPS      = 250;
  localparam int REPORT_MAX     = 10;

  // one result transaction as seen on the output channel
  typedef struct packed {
    status_t                status;
    logic [REC_IDX_W-1:0]   record_index;
    logic [REC_BLK_W-1:0]   record_blocks;
    logic [FILL_W-1:0]      pad_blocks;
    logic [TYPE_W-1:0]      head_type;
    logic                   external_payload;
    logic                   ring_empty;
  } ring_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: ring predictor plus queue of expected results
  // --------------------------------------------------------------------------
  class ring_scoreboard;
    ring_result_t     expected_q[$];
    hdr_t             hdr_mem[RING_BLOCKS];
    logic [IDX_W-1:0] rd_pos;
    logic [IDX_W-1:0] wr_pos;
    logic [IDX_W-1:0] pend_end;
    bit               rsv_open;
    bit               spill;
    int               mismatches;

    function new();
      rd_pos     = '0;
      wr_pos     = '0;
      pend_end   = '0;
      rsv_open   = 1'b0;
      spill      = 1'b0;
      mismatches = 0;
    endfunction

    function void set_spill(bit v);
      spill = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // blocks a filler must cover when the record would run past the ring end
    function int tail_fill(int nblk);
      int room;
      room = RING_BLOCKS - int'(wr_pos);
      return (nblk > room) ? room : 0;
    endfunction

    // predict the result of one accepted operation
    function void note_op(kind_t k, logic [TYPE_W-1:0] rtype, logic [BYTES_W-1:0] nbytes);
      ring_result_t     r;
      logic [IDX_W-1:0] room_left;
      logic [IDX_W-1:0] at;
      int               nblk;
      int               fill;
      bit               is_ext;
      bit               fits;
      r = '0;
      case (k)
        KIND_RESERVE: begin
          if (rsv_open) begin
            r.status = ST_BAD_STATE;
          end else begin
            room_left = rd_pos - wr_pos - 1'b1;
            is_ext = (int'(nbytes) + BLOCK_BYTES > BLOCK_BYTES * RING_BLOCKS / 2);
            nblk = is_ext ? 1 : 1 + (int'(nbytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
            fill = tail_fill(nblk);
            fits = (nblk + fill <= int'(room_left));
            // spill mode: inline record that does not fit retries as one external block
            if (!fits && spill && !is_ext && nbytes != 0) begin
              is_ext = 1'b1;
              nblk = 1;
              fill = tail_fill(nblk);
              fits = (nblk + fill <= int'(room_left));
            end
            if (!fits) begin
              r.status = ST_FULL;
            end else begin
              at = wr_pos;
              if (fill != 0) begin
                hdr_mem[at] = '{rtype: '0, blocks: CNT_W'(fill), ext: 1'b0};
                at = '0;
              end
              hdr_mem[at] = '{rtype: rtype, blocks: CNT_W'(nblk), ext: is_ext};
              pend_end = wr_pos + IDX_W'(nblk + fill);
              rsv_open = 1'b1;
              r.record_index     = at;
              r.record_blocks    = REC_BLK_W'(nblk);
              r.pad_blocks       = FILL_W'(fill);
              r.external_payload = is_ext;
            end
          end
        end
        KIND_COMMIT: begin
          if (!rsv_open) begin
            r.status = ST_BAD_STATE;
          end else begin
            wr_pos   = pend_end;
            rsv_open = 1'b0;
          end
        end
        default: begin
          // peek and pop both report the head header
          if (rd_pos == wr_pos) begin
            r.status = ST_EMPTY;
          end else begin
            at = rd_pos;
            r.record_index     = at;
            r.record_blocks    = REC_BLK_W'(hdr_mem[at].blocks);
            r.head_type        = hdr_mem[at].rtype;
            r.external_payload = hdr_mem[at].ext;
            if (k == KIND_POP) rd_pos = rd_pos + IDX_W'(hdr_mem[at].blocks);
          end
        end
      endcase
      r.ring_empty = (rd_pos == wr_pos);
      expected_q.push_back(r);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(ring_result_t got);
      ring_result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: st=%0d idx=%0d blk=%0d fill=%0d type=%h ext=%0d empty=%0d",
                   got.status, got.record_index, got.record_blocks, got.pad_blocks,
                   got.head_type, got.external_payload, got.ring_empty);
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status || got.record_index !== exp.record_index ||
          got.record_blocks !== exp.record_blocks || got.pad_blocks !== exp.pad_blocks ||
          got.head_type !== exp.head_type || got.external_payload !== exp.external_payload ||
          got.ring_empty !== exp.ring_empty) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch exp: st=%0d idx=%0d blk=%0d fill=%0d type=%h ext=%0d empty=%0d",
                   exp.status, exp.record_index, exp.record_blocks, exp.pad_blocks,
                   exp.head_type, exp.external_payload, exp.ring_empty);
          $display("         got: st=%0d idx=%0d blk=%0d fill=%0d type=%h ext=%0d empty=%0d",
                   got.status, got.record_index, got.record_blocks, got.pad_blocks,
                   got.head_type, got.external_payload, got.ring_empty);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  vrra_in_if  in_ch();
  vrra_out_if out_ch();

  ring_scoreboard sb;
  bit             no_idle = 1'b0;
  int             rx_hold = 0;
  int             ops_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  variable_record_ring_allocator_top dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Driver tasks (called at a rising edge)
  // --------------------------------------------------------------------------

  // offer one operation and wait until it is taken
  task automatic issue_op(kind_t k, logic [TYPE_W-1:0] rtype, logic [BYTES_W-1:0] nbytes);
    int gap;
    bit took;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= k;
    in_ch.record_type   <= rtype;
    in_ch.payload_bytes <= nbytes;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    sb.note_op(k, rtype, nbytes);
    ops_sent++;
  endtask

  // APB write of the spill register: setup then access phase
  task automatic write_spill(bit v);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SPILL_WHEN_FULL, 2'b00};
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_spill(v);
  endtask

  // stop offering and wait for every predicted result
  task automatic settle();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic logic [TYPE_W-1:0] pick_type();
    return TYPE_W'($urandom_range(1, 65535));
  endfunction

  // payload sizes: mostly small, some near the external threshold, some anything
  function automatic logic [BYTES_W-1:0] pick_bytes();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return BYTES_W'($urandom_range(0, 64));
    if (p < 65) return BYTES_W'($urandom_range(65, 600));
    if (p < 80) return BYTES_W'($urandom_range(2016, 2048));
    if (p < 95) return BYTES_W'($urandom);
    return '0;
  endfunction

  // random traffic: reserve/commit pairs against pops and peeks, plus noise
  task automatic run_random(int n_ops, int pop_pct);
    int stop;
    int r;
    stop = ops_sent + n_ops;
    while (ops_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        issue_op(KIND_RESERVE, pick_type(), pick_bytes());
        if ($urandom_range(0, 4) == 0)
          issue_op($urandom_range(0, 1) ? KIND_PEEK : KIND_POP, pick_type(), pick_bytes());
        issue_op(KIND_COMMIT, pick_type(), pick_bytes());
      end else if (r < 40 + pop_pct) begin
        issue_op(KIND_POP, pick_type(), pick_bytes());
      end else if (r < 48 + pop_pct) begin
        issue_op(KIND_PEEK, pick_type(), pick_bytes());
      end else begin
        issue_op(kind_t'($urandom_range(0, 3)), TYPE_W'($urandom), BYTES_W'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready, optional long hold, check each transaction
  // --------------------------------------------------------------------------
  initial begin
    int           gap;
    bit           got;
    ring_result_t res;
    out_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_ch.valid;
        res.status           = status_t'(out_ch.status);
        res.record_index     = out_ch.record_index;
        res.record_blocks    = out_ch.record_blocks;
        res.pad_blocks       = out_ch.pad_blocks;
        res.head_type        = out_ch.head_type;
        res.external_payload = out_ch.external_payload;
        res.ring_empty       = out_ch.ring_empty;
        @(posedge clk);
      end while (!got);
      sb.check_result(res);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no transaction on any port
  // --------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit spill_plan[6];
    int pop_plan[6];
    sb = new();
    spill_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    pop_plan   = '{30, 35, 25, 40, 28, 36};

    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_PEEK;
    in_ch.record_type   <= '0;
    in_ch.payload_bytes <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst     <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty ring, bad state, boundary sizes, type zero, filler, full
    write_spill(1'b0);
    issue_op(KIND_PEEK,    16'h1234, 16'd0);
    issue_op(KIND_POP,     16'h1234, 16'd0);
    issue_op(KIND_COMMIT,  16'h0001, 16'd0);
    issue_op(KIND_RESERVE, 16'hFFFF, 16'd0);
    issue_op(KIND_RESERVE, 16'h0002, 16'd5);      // second reserve while open
    issue_op(KIND_COMMIT,  16'h0000, 16'd0);
    issue_op(KIND_PEEK,    16'h0000, 16'hFFFF);
    issue_op(KIND_RESERVE, 16'h0000, 16'd2032);   // type zero, largest inline payload
    issue_op(KIND_COMMIT,  16'h0000, 16'd0);
    issue_op(KIND_RESERVE, 16'h0001, 16'd2033);   // smallest external payload
    issue_op(KIND_COMMIT,  16'h0000, 16'd0);
    issue_op(KIND_RESERVE, 16'h8000, 16'hFFFF);
    issue_op(KIND_COMMIT,  16'h0000, 16'd0);
    repeat (4) issue_op(KIND_POP, 16'h0000, 16'd0);
    issue_op(KIND_RESERVE, 16'h5A5A, 16'd2032);   // needs a filler over the tail
    issue_op(KIND_COMMIT,  16'h0000, 16'd0);
    issue_op(KIND_RESERVE, 16'hA5A5, 16'd2032);   // does not fit
    settle();

    // directed: spill retry, then full even after retry
    write_spill(1'b1);
    issue_op(KIND_RESERVE, 16'h00FF, 16'd2032);
    issue_op(KIND_COMMIT,  16'h0000, 16'd0);
    issue_op(KIND_RESERVE, 16'hFF00, 16'd0);
    issue_op(KIND_COMMIT,  16'h0000, 16'd0);
    issue_op(KIND_RESERVE, 16'h0F0F, 16'd100);
    issue_op(KIND_RESERVE, 16'hF0F0, 16'd0);
    settle();

    // random phases, each closed by a full drain
    for (int p = 0; p < 6; p++) begin
      write_spill(spill_plan[p]);
      no_idle = (p == 1);
      if (p == 2) begin
        // long result-side stall while requests keep coming
        run_random(40, pop_plan[p]);
        rx_hold = HOLD_CYCLES;
        run_random(PHASE_OPS - 40, pop_plan[p]);
      end else begin
        run_random(PHASE_OPS, pop_plan[p]);
      end
      settle();
    end
    no_idle = 1'b0;
    repeat (4) @(posedge clk);

    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/vrra_pkg.sv
hw/rtl/vrra_in_if.sv
hw/rtl/vrra_out_if.sv
hw/rtl/vrra_ram.sv
hw/rtl/vrra_apb_regs.sv
hw/rtl/vrra_core.sv
hw/rtl/variable_record_ring_allocator_top.sv
sim/tb_variable_record_ring_allocator_top.sv
